>>> rtl/euler_yxz_to_scaled_rotation_defines.svh
// Assertion macros for the euler_yxz_to_scaled_rotation checker.
// Both expect clk and arst_n in scope.
`ifndef EULER_YXZ_TO_SCALED_ROTATION_DEFINES_SVH
`define EULER_YXZ_TO_SCALED_ROTATION_DEFINES_SVH

// Same-cycle implication.
`define EYX_ASSERT_IMM(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EYX_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/eyx_pkg.sv
`timescale 1ns / 1ps
package eyx_pkg;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int OUT_WIDTH_DEF = 32;
	localparam int TRIG_STAGES_DEF = 16;
	localparam int MAX_STAGES = 32;

	localparam int PHASE_W = 64;
	localparam int PHASE_FRAC = 60;
	localparam int TRIG_W = 33;
	localparam int TRIG_FRAC = 30;
	localparam int VEC_FRAC = 24;
	localparam int SCALE_FRAC = 14;
	localparam int OUT_FRAC = 22;
	localparam int SCALE_W = 16;

	localparam int DIR_W = 27;
	localparam int ZW = 28;
	localparam int UW = 32;
	localparam int WW = 36;
	localparam int TW = 38;
	localparam int YW = 40;
	localparam int XW = 48;

	localparam int TAG_W = 1 + 2 * SCALE_W;
	localparam int VEC_STAGES = 15;

	typedef logic signed [PHASE_W-1:0] phase_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef phase_t atan_tab_t [MAX_STAGES];

	typedef struct packed {
		trig_t x;
		trig_t y;
		phase_t a;
		logic flip;
	} lane_t;

	typedef struct packed {
		lane_t [2:0] lane;
		logic [TAG_W-1:0] tag;
	} cordic_t;

	localparam trig_t CORDIC_GAIN = 33'sd652032874;

	// shift and subtract quotient, used only for the constant tables
	function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// pi = 16 atan(1/5) - 4 atan(1/239), truncated series in Q60
	function automatic phase_t pi_q60();
		logic [63:0] p;
		logic [63:0] s5;
		logic [63:0] s239;
		s5 = '0;
		p = udiv(64'd1 << PHASE_FRAC, 64'd5);
		for (int k = 0; k < 64; k++) begin
			if ((k & 1) == 0) s5 = s5 + udiv(p, 64'(2 * k + 1));
			else s5 = s5 - udiv(p, 64'(2 * k + 1));
			p = udiv(p, 64'd25);
		end
		s239 = '0;
		p = udiv(64'd1 << PHASE_FRAC, 64'd239);
		for (int k = 0; k < 64; k++) begin
			if ((k & 1) == 0) s239 = s239 + udiv(p, 64'(2 * k + 1));
			else s239 = s239 - udiv(p, 64'(2 * k + 1));
			p = udiv(p, 64'd57121);
		end
		return phase_t'(64'd16 * s5 - 64'd4 * s239);
	endfunction

	function automatic atan_tab_t atan_table();
		atan_tab_t tab;
		logic [63:0] p;
		logic [63:0] s;
		tab[0] = pi_q60() >>> 2;
		for (int i = 1; i < MAX_STAGES; i++) begin
			s = '0;
			p = 64'd1 << (PHASE_FRAC - i);
			for (int k = 0; k < 64; k++) begin
				if ((k & 1) == 0) s = s + udiv(p, 64'(2 * k + 1));
				else s = s - udiv(p, 64'(2 * k + 1));
				p = p >> (2 * i);
			end
			tab[i] = phase_t'(s);
		end
		return tab;
	endfunction

	localparam phase_t PI_Q60 = pi_q60();
	localparam atan_tab_t ATAN_TAB = atan_table();
endpackage

>>> rtl/eyx_cordic_cell.sv
`timescale 1ns / 1ps
module eyx_cordic_cell import eyx_pkg::*; #(
	parameter int STAGE = 0
) (
	input logic clk,
	input logic en,
	input cordic_t din,
	output cordic_t dout
);
	trig_t dx [3];
	trig_t dy [3];
	cordic_t nxt;

	always_comb begin
		nxt = din;
		for (int l = 0; l < 3; l++) begin
			dx[l] = din.lane[l].y >>> STAGE;
			dy[l] = din.lane[l].x >>> STAGE;
			if (din.lane[l].a >= 0) begin
				nxt.lane[l].x = din.lane[l].x - dx[l];
				nxt.lane[l].y = din.lane[l].y + dy[l];
				nxt.lane[l].a = din.lane[l].a - ATAN_TAB[STAGE];
			end else begin
				nxt.lane[l].x = din.lane[l].x + dx[l];
				nxt.lane[l].y = din.lane[l].y - dy[l];
				nxt.lane[l].a = din.lane[l].a + ATAN_TAB[STAGE];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end
endmodule

>>> rtl/eyx_trig.sv
`timescale 1ns / 1ps
module eyx_trig import eyx_pkg::*; #(
	parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
	input logic clk,
	input logic en,
	input phase_t angle [3],
	input logic [TAG_W-1:0] tag_in,
	output trig_t sin_val [3],
	output trig_t cos_val [3],
	output logic [TAG_W-1:0] tag_out
);
	localparam phase_t HALF_PI = PI_Q60 >>> 1;

	cordic_t red;
	cordic_t red_s1;
	cordic_t chain [TRIG_STAGES+1];

	// fold into [-pi/2, pi/2], negate both results afterwards
	always_comb begin
		red.tag = tag_in;
		for (int l = 0; l < 3; l++) begin
			red.lane[l].x = CORDIC_GAIN;
			red.lane[l].y = '0;
			red.lane[l].a = angle[l];
			red.lane[l].flip = 1'b0;
			if (angle[l] > HALF_PI) begin
				red.lane[l].a = angle[l] - PI_Q60;
				red.lane[l].flip = 1'b1;
			end else if (angle[l] < -HALF_PI) begin
				red.lane[l].a = angle[l] + PI_Q60;
				red.lane[l].flip = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) red_s1 <= red;
	end

	assign chain[0] = red_s1;

	for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
		eyx_cordic_cell #(.STAGE(g)) u_cell (
			.clk (clk),
			.en  (en),
			.din (chain[g]),
			.dout(chain[g+1])
		);
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sin_val[l] = chain[TRIG_STAGES].lane[l].flip ?
				-chain[TRIG_STAGES].lane[l].y : chain[TRIG_STAGES].lane[l].y;
			cos_val[l] = chain[TRIG_STAGES].lane[l].flip ?
				-chain[TRIG_STAGES].lane[l].x : chain[TRIG_STAGES].lane[l].x;
		end
	end

	assign tag_out = chain[TRIG_STAGES].tag;
endmodule

>>> rtl/eyx_vec.sv
`timescale 1ns / 1ps
module eyx_vec import eyx_pkg::*; #(
	parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
	input logic clk,
	input logic en,
	input trig_t sin_val [3],
	input trig_t cos_val [3],
	input logic [TAG_W-1:0] tag,
	output logic signed [OUT_WIDTH-1:0] xcol [3],
	output logic signed [OUT_WIDTH-1:0] ycol [3],
	output logic signed [OUT_WIDTH-1:0] zcol [3],
	output logic saturated
);
	typedef struct packed {
		logic [SCALE_W-1:0] zs;
		logic [SCALE_W-1:0] ys;
		trig_t sr;
		trig_t cr;
	} side_t;

	localparam int TT_W = 2 * TRIG_W;
	localparam int ZP_W = SCALE_W + 1 + DIR_W;
	localparam int ZZ_W = 2 * ZW + 1;
	localparam int UZ_W = UW + ZW + 1;
	localparam int UC_W = UW + TRIG_W;
	localparam int WS_W = WW + TRIG_W;
	localparam int TY_W = SCALE_W + 1 + TW;
	localparam int YZ_W = YW + ZW + 1;
	localparam int EW = (XW > OUT_WIDTH) ? XW : OUT_WIDTH + 1;
	localparam int SH_TT = 2 * TRIG_FRAC - VEC_FRAC;
	localparam int SH_T = TRIG_FRAC - VEC_FRAC;
	localparam int SH_O = VEC_FRAC - OUT_FRAC;

	localparam logic signed [TT_W-1:0] RND_TT = TT_W'(1) <<< (SH_TT - 1);
	localparam trig_t RND_T = TRIG_W'(1) <<< (SH_T - 1);
	localparam logic signed [ZP_W-1:0] RND_ZP = ZP_W'(1) <<< (SCALE_FRAC - 1);
	localparam logic signed [ZZ_W-1:0] RND_ZZ = ZZ_W'(1) <<< (VEC_FRAC - 1);
	localparam logic signed [UZ_W-1:0] RND_UZ = UZ_W'(1) <<< (VEC_FRAC - 1);
	localparam logic signed [UC_W-1:0] RND_UC = UC_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [WS_W-1:0] RND_WS = WS_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [TY_W-1:0] RND_TY = TY_W'(1) <<< (SCALE_FRAC - 1);
	localparam logic signed [YZ_W-1:0] RND_YZ = YZ_W'(1) <<< (VEC_FRAC - 1);
	localparam logic signed [XW-1:0] RND_O = XW'(1) <<< (SH_O - 1);
	localparam logic signed [EW-1:0] HI =
		{{(EW - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
	localparam logic signed [EW-1:0] LO = ~HI;

	trig_t cy_sel;
	logic signed [TT_W-1:0] pcs_s1, pcc_s1;
	trig_t sp_s1;
	logic inr_s1;
	side_t side_s [1:10];
	logic signed [DIR_W-1:0] dir_s2 [3];
	logic signed [ZP_W-1:0] zp_s3 [3];
	logic signed [ZW-1:0] z_s [4:14][3];
	logic signed [ZZ_W-2:0] pz_s5 [4];
	logic signed [UW-1:0] u_s [6:8][3];
	logic signed [UZ_W-2:0] pu_s7 [6];
	logic signed [WW-1:0] w_s8 [3];
	logic signed [UC_W-1:0] uc_s9 [3];
	logic signed [WS_W-1:0] ws_s9 [3];
	logic signed [TW-1:0] t_s10 [3];
	logic signed [TY_W-1:0] ty_s11 [3];
	logic signed [YW-1:0] y_s [12:14][3];
	logic signed [YZ_W-2:0] py_s13 [6];
	logic signed [XW-1:0] x_s14 [3];
	logic signed [XW-1:0] ent [9];
	logic signed [XW-1:0] rq [9];
	logic signed [EW-1:0] qe [9];
	logic signed [OUT_WIDTH-1:0] ov [9];
	logic [8:0] clip;

	// yaw outside [-pi, pi): |cos y|, and the x term is forced to zero below
	assign cy_sel = (tag[TAG_W-1] || !cos_val[1][TRIG_W-1]) ? cos_val[1] : -cos_val[1];

	always_ff @(posedge clk) begin
		if (en) begin
			pcs_s1 <= cos_val[0] * sin_val[1];
			pcc_s1 <= cos_val[0] * cy_sel;
			sp_s1 <= sin_val[0];
			inr_s1 <= tag[TAG_W-1];
			side_s[1] <= '{zs: tag[SCALE_W-1:0], ys: tag[2*SCALE_W-1:SCALE_W],
				sr: sin_val[2], cr: cos_val[2]};
			for (int k = 2; k <= 10; k++) side_s[k] <= side_s[k-1];

			dir_s2[0] <= inr_s1 ? DIR_W'((pcs_s1 + RND_TT) >>> SH_TT) : '0;
			dir_s2[1] <= DIR_W'((sp_s1 + RND_T) >>> SH_T);
			dir_s2[2] <= DIR_W'((pcc_s1 + RND_TT) >>> SH_TT);

			for (int i = 0; i < 3; i++) begin
				zp_s3[i] <= $signed({1'b0, side_s[2].zs}) * dir_s2[i];
				z_s[4][i] <= ZW'((zp_s3[i] + RND_ZP) >>> SCALE_FRAC);
			end
			for (int k = 5; k <= 14; k++) z_s[k] <= z_s[k-1];

			pz_s5[0] <= z_s[4][1] * z_s[4][0];
			pz_s5[1] <= z_s[4][2] * z_s[4][2];
			pz_s5[2] <= z_s[4][0] * z_s[4][0];
			pz_s5[3] <= z_s[4][1] * z_s[4][2];

			// u = Z x (Z.z, 0, -Z.x)
			u_s[6][0] <= UW'((RND_ZZ - pz_s5[0]) >>> VEC_FRAC);
			u_s[6][1] <= UW'((pz_s5[1] + pz_s5[2] + RND_ZZ) >>> VEC_FRAC);
			u_s[6][2] <= UW'((RND_ZZ - pz_s5[3]) >>> VEC_FRAC);
			u_s[7] <= u_s[6];
			u_s[8] <= u_s[7];

			// w = u x Z
			pu_s7[0] <= u_s[6][1] * z_s[6][2];
			pu_s7[1] <= u_s[6][2] * z_s[6][1];
			pu_s7[2] <= u_s[6][2] * z_s[6][0];
			pu_s7[3] <= u_s[6][0] * z_s[6][2];
			pu_s7[4] <= u_s[6][0] * z_s[6][1];
			pu_s7[5] <= u_s[6][1] * z_s[6][0];

			for (int i = 0; i < 3; i++) begin
				w_s8[i] <= WW'((pu_s7[2*i] - pu_s7[2*i+1] + RND_UZ) >>> VEC_FRAC);
				uc_s9[i] <= u_s[8][i] * side_s[8].cr;
				ws_s9[i] <= w_s8[i] * side_s[8].sr;
				t_s10[i] <= TW'((uc_s9[i] + RND_UC) >>> TRIG_FRAC) +
					TW'((ws_s9[i] + RND_WS) >>> TRIG_FRAC);
				ty_s11[i] <= $signed({1'b0, side_s[10].ys}) * t_s10[i];
				y_s[12][i] <= YW'((ty_s11[i] + RND_TY) >>> SCALE_FRAC);
			end
			y_s[13] <= y_s[12];
			y_s[14] <= y_s[13];

			// x = y x Z
			py_s13[0] <= y_s[12][1] * z_s[12][2];
			py_s13[1] <= y_s[12][2] * z_s[12][1];
			py_s13[2] <= y_s[12][2] * z_s[12][0];
			py_s13[3] <= y_s[12][0] * z_s[12][2];
			py_s13[4] <= y_s[12][0] * z_s[12][1];
			py_s13[5] <= y_s[12][1] * z_s[12][0];

			for (int i = 0; i < 3; i++) begin
				x_s14[i] <= XW'((py_s13[2*i] - py_s13[2*i+1] + RND_YZ) >>> VEC_FRAC);
			end

			for (int i = 0; i < 3; i++) begin
				xcol[i] <= ov[i];
				ycol[i] <= ov[3+i];
				zcol[i] <= ov[6+i];
			end
			saturated <= |clip;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ent[i] = x_s14[i];
			ent[3+i] = XW'(y_s[14][i]);
			ent[6+i] = XW'(z_s[14][i]);
		end
		for (int k = 0; k < 9; k++) begin
			rq[k] = (ent[k] + RND_O) >>> SH_O;
			qe[k] = EW'(rq[k]);
			clip[k] = 1'b1;
			if (qe[k] > HI) ov[k] = HI[OUT_WIDTH-1:0];
			else if (qe[k] < LO) ov[k] = LO[OUT_WIDTH-1:0];
			else begin
				ov[k] = qe[k][OUT_WIDTH-1:0];
				clip[k] = 1'b0;
			end
		end
	end
endmodule

>>> rtl/euler_yxz_to_scaled_rotation.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless stalled (CORDIC chain, vector pipeline).
// A result held at the output stalls the whole pipeline; input is taken whenever
// the output register is free or being drained.
// Reset (arst_n low) clears the stage valid bits only; no payload is reset.
module euler_yxz_to_scaled_rotation import eyx_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
	parameter int OUT_WIDTH = OUT_WIDTH_DEF,
	parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [ANGLE_WIDTH-1:0] pitch_angle,
	input logic signed [ANGLE_WIDTH-1:0] yaw_angle,
	input logic signed [ANGLE_WIDTH-1:0] roll_angle,
	input logic [SCALE_W-1:0] y_scale,
	input logic [SCALE_W-1:0] z_scale,
	output logic out_valid,
	input logic out_ready,
	output logic signed [OUT_WIDTH-1:0] xcol_x,
	output logic signed [OUT_WIDTH-1:0] xcol_y,
	output logic signed [OUT_WIDTH-1:0] xcol_z,
	output logic signed [OUT_WIDTH-1:0] ycol_x,
	output logic signed [OUT_WIDTH-1:0] ycol_y,
	output logic signed [OUT_WIDTH-1:0] ycol_z,
	output logic signed [OUT_WIDTH-1:0] zcol_x,
	output logic signed [OUT_WIDTH-1:0] zcol_y,
	output logic signed [OUT_WIDTH-1:0] zcol_z,
	output logic saturated
);
	localparam int ANG_SHIFT = PHASE_FRAC - (ANGLE_WIDTH - 3);
	localparam int LAT = 1 + TRIG_STAGES + VEC_STAGES;

	logic adv;
	logic [LAT-1:0] valid_s;
	phase_t ang [3];
	logic yaw_in;
	logic [TAG_W-1:0] tag_in, tag_out;
	trig_t sin_val [3];
	trig_t cos_val [3];
	logic signed [OUT_WIDTH-1:0] xcol [3];
	logic signed [OUT_WIDTH-1:0] ycol [3];
	logic signed [OUT_WIDTH-1:0] zcol [3];

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign out_valid = valid_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[LAT-2:0], in_valid};
		end
	end

	assign ang[0] = phase_t'(pitch_angle) <<< ANG_SHIFT;
	assign ang[1] = phase_t'(yaw_angle) <<< ANG_SHIFT;
	assign ang[2] = phase_t'(roll_angle) <<< ANG_SHIFT;
	assign yaw_in = (ang[1] >= -PI_Q60) && (ang[1] < PI_Q60);
	assign tag_in = {yaw_in, y_scale, z_scale};

	eyx_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig (
		.clk    (clk),
		.en     (adv),
		.angle  (ang),
		.tag_in (tag_in),
		.sin_val(sin_val),
		.cos_val(cos_val),
		.tag_out(tag_out)
	);

	eyx_vec #(.OUT_WIDTH(OUT_WIDTH)) u_vec (
		.clk      (clk),
		.en       (adv),
		.sin_val  (sin_val),
		.cos_val  (cos_val),
		.tag      (tag_out),
		.xcol     (xcol),
		.ycol     (ycol),
		.zcol     (zcol),
		.saturated(saturated)
	);

	assign xcol_x = xcol[0];
	assign xcol_y = xcol[1];
	assign xcol_z = xcol[2];
	assign ycol_x = ycol[0];
	assign ycol_y = ycol[1];
	assign ycol_z = ycol[2];
	assign zcol_x = zcol[0];
	assign zcol_y = zcol[1];
	assign zcol_z = zcol[2];
endmodule

>>> rtl/eyx_checker.sv
`timescale 1ns / 1ps
`include "euler_yxz_to_scaled_rotation_defines.svh"
module eyx_checker import eyx_pkg::*; #(
	parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [OUT_WIDTH-1:0] xcol_x,
	input logic signed [OUT_WIDTH-1:0] ycol_y,
	input logic signed [OUT_WIDTH-1:0] zcol_z,
	input logic saturated
);
	`EYX_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`EYX_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(xcol_x) && $stable(ycol_y) && $stable(zcol_z) && $stable(saturated), "result changed while stalled")
	`EYX_ASSERT_IMM(a_take_when_empty, !out_valid, in_ready, "input refused with empty output")
	`EYX_ASSERT_IMM(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "input taken during stall")
endmodule

bind euler_yxz_to_scaled_rotation eyx_checker #(.OUT_WIDTH(OUT_WIDTH)) u_eyx_checker (.*);
